[hdl/vertex_transform_project_core_macros.svh]
// Assertion macros for the vertex transform RTL.
`ifndef VERTEX_TRANSFORM_PROJECT_CORE_MACROS_SVH
`define VERTEX_TRANSFORM_PROJECT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define VTP_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("vtp assertion failed");
// next-cycle implication
`define VTP_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("vtp assertion failed");
`else
`define VTP_ASSERT_IMP(label, clk, rst, a, c)
`define VTP_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

[hdl/vtp_pkg.sv]
package vtp_pkg;

  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_W         = 64;
  localparam int COORD_W       = 32;
  localparam int PROD_W        = 64;
  // dividend width: |r| << FRAC_BITS always fits here
  localparam int NUM_W         = 66;
  localparam int QUO_W         = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FIFO_DEPTH    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

  localparam logic [COORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] NEG_MIN = 32'h8000_0000;

  typedef struct packed {
    logic                neg;      // quotient sign
    logic                ovf;      // quotient >= 2^32
    logic                rneg;     // row sum below zero
    logic                aff_sat;
    logic [COORD_W-1:0]  aff_val;
  } lane_meta_t;

  typedef struct packed {
    logic             action;
    logic             dz;
    lane_meta_t [2:0] lane;
  } meta_t;

endpackage

[hdl/vertex_transform_project_core.sv]
// Vertex transform with optional perspective divide, Q16.16 by default.
// Input channel: in_valid / in_stall carry action, x_in, y_in, z_in; a word is
//   taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry x_out, y_out, z_out, saturated
//   and divide_by_zero; one result word per input word, in order.
// Matrix: eight 64-bit registers written through wr_en / wr_index / wr_data;
//   indexes past the last register are ignored. Write only while idle.
// Front: 12 multipliers in one stage, then floor shift and row sums, into a
//   four-word queue. Back: sign/overflow stage, a 32-stage restoring divider
//   (one quotient bit per stage, three lanes), then the output register.
// Every word, affine or projected, walks the same back pipeline.
// Throughput: one word per cycle while out_stall stays low.
// Reset (rst, synchronous): matrix returns to identity, all valids clear.
// out_stall freezes the back pipeline; the queue then fills and in_stall rises
//   only once the queue is full and the second front stage holds a word.
module vertex_transform_project_core #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [vtp_pkg::CFG_W-1:0]          wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               action,
  input  logic signed [vtp_pkg::COORD_W-1:0] x_in,
  input  logic signed [vtp_pkg::COORD_W-1:0] y_in,
  input  logic signed [vtp_pkg::COORD_W-1:0] z_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [vtp_pkg::COORD_W-1:0] x_out,
  output logic signed [vtp_pkg::COORD_W-1:0] y_out,
  output logic signed [vtp_pkg::COORD_W-1:0] z_out,
  output logic                               saturated,
  output logic                               divide_by_zero
);

  // queued word: action bit plus four row sums
  localparam int RW = vtp_pkg::NUM_W - FRAC_BITS;
  localparam int QW = 4 * RW + 1;

  logic          push, full, pop, q_valid;
  logic [QW-1:0] push_data, q_data;

  vtp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .x_in      (x_in),
    .y_in      (y_in),
    .z_in      (z_in),
    .push      (push),
    .full      (full),
    .push_data (push_data)
  );

  vtp_fifo #(.W(QW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  vtp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .fifo_valid     (q_valid),
    .fifo_data      (q_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .x_out          (x_out),
    .y_out          (y_out),
    .z_out          (z_out),
    .saturated      (saturated),
    .divide_by_zero (divide_by_zero)
  );

endmodule

[hdl/vtp_front.sv]
module vtp_front #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF,
  localparam int RW = vtp_pkg::NUM_W - FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [vtp_pkg::CFG_W-1:0]       wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic signed [vtp_pkg::COORD_W-1:0] x_in,
  input  logic signed [vtp_pkg::COORD_W-1:0] y_in,
  input  logic signed [vtp_pkg::COORD_W-1:0] z_in,
  output logic                            push,
  input  logic                            full,
  output logic [4*RW:0]                   push_data
);

  localparam logic [vtp_pkg::CFG_W-1:0] ONE = vtp_pkg::CFG_W'(1) << FRAC_BITS;

  logic [vtp_pkg::CFG_W-1:0] cfg [vtp_pkg::NUM_REGS];
  logic signed [vtp_pkg::COORD_W-1:0] m [4][4];
  logic signed [vtp_pkg::COORD_W-1:0] vec [3];

  logic                              v1, v2, act1, act2, front_en;
  logic signed [vtp_pkg::PROD_W-1:0] prod [4][3];
  logic signed [vtp_pkg::COORD_W-1:0] m3 [4];
  logic signed [RW-1:0]              sum [4];
  logic signed [RW-1:0]              r2 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      // identity matrix
      for (int i = 0; i < vtp_pkg::NUM_REGS; i++) begin
        if (vtp_pkg::CFG_IDX_W'(i) inside {vtp_pkg::REG_ROW0_COLS01,
                                           vtp_pkg::REG_ROW2_COLS23}) begin
          cfg[i] <= ONE;
        end else if (vtp_pkg::CFG_IDX_W'(i) inside {vtp_pkg::REG_ROW1_COLS01,
                                                    vtp_pkg::REG_ROW3_COLS23}) begin
          cfg[i] <= ONE << 32;
        end else begin
          cfg[i] <= '0;
        end
      end
    end else if (wr_en && (wr_index < vtp_pkg::CFG_IDX_W'(vtp_pkg::NUM_REGS))) begin
      cfg[wr_index[2:0]] <= wr_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        m[r][c] = signed'(cfg[2*r + c/2][(c%2)*32 +: 32]);
    vec[0] = x_in;
    vec[1] = y_in;
    vec[2] = z_in;
  end

  assign front_en = !(v2 && full);
  assign in_stall = !front_en;
  assign push     = v2 && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (front_en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // stage 1: twelve products
  always_ff @(posedge clk) begin
    if (front_en) begin
      act1 <= action;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) prod[r][c] <= m[r][c] * vec[c];
        m3[r] <= m[r][3];
      end
    end
  end

  // stage 2: floor shift and row sums
  always_comb begin
    for (int r = 0; r < 4; r++)
      sum[r] = RW'(signed'(prod[r][0][vtp_pkg::PROD_W-1:FRAC_BITS]))
             + RW'(signed'(prod[r][1][vtp_pkg::PROD_W-1:FRAC_BITS]))
             + RW'(signed'(prod[r][2][vtp_pkg::PROD_W-1:FRAC_BITS]))
             + RW'(m3[r]);
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      act2 <= act1;
      for (int r = 0; r < 4; r++) r2[r] <= sum[r];
    end
  end

  assign push_data = {act2, r2[3], r2[2], r2[1], r2[0]};

endmodule

[hdl/vtp_fifo.sv]
module vtp_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] data
);

  localparam int DEPTH = vtp_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

[hdl/vtp_div.sv]
module vtp_div #(
  parameter int DW = 50
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [vtp_pkg::NUM_W-1:0] num,
  input  logic [DW-1:0]             den,
  output logic [vtp_pkg::QUO_W-1:0] quo
);

  localparam int NW = vtp_pkg::NUM_W;
  localparam int QW = vtp_pkg::QUO_W;

  logic [NW-1:0] rem   [QW];
  logic [DW-1:0] den_s [QW];
  logic [QW-1:0] q_s   [QW];
  logic [NW-1:0] rin   [QW];
  logic [DW-1:0] din   [QW];
  logic [QW-1:0] qin   [QW];

  // one quotient bit per stage, msb first
  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    if (j == 0) begin : g_first
      assign rin[j] = num;
      assign din[j] = den;
      assign qin[j] = '0;
    end else begin : g_next
      assign rin[j] = rem[j-1];
      assign din[j] = den_s[j-1];
      assign qin[j] = q_s[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_s[j] <= din[j];
        if ((rin[j] >> K) >= NW'(din[j])) begin
          rem[j] <= rin[j] - (NW'(din[j]) << K);
          q_s[j] <= qin[j] | (QW'(1) << K);
        end else begin
          rem[j] <= rin[j];
          q_s[j] <= qin[j];
        end
      end
    end
  end

  assign quo = q_s[QW-1];

endmodule

[hdl/vtp_back.sv]
`include "vertex_transform_project_core_macros.svh"

module vtp_back #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF,
  localparam int RW = vtp_pkg::NUM_W - FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fifo_valid,
  input  logic [4*RW:0]                      fifo_data,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [vtp_pkg::COORD_W-1:0] x_out,
  output logic signed [vtp_pkg::COORD_W-1:0] y_out,
  output logic signed [vtp_pkg::COORD_W-1:0] z_out,
  output logic                               saturated,
  output logic                               divide_by_zero
);

  localparam int NW = vtp_pkg::NUM_W;
  localparam int QW = vtp_pkg::QUO_W;
  localparam int CW = vtp_pkg::COORD_W;

  logic          back_en;
  logic signed [RW-1:0] r [4];
  logic [RW-1:0] wm, rm [3];
  logic          wneg;
  vtp_pkg::meta_t meta_c, meta_p;
  logic [NW-1:0] num_c [3];
  logic [NW-1:0] num_p [3];
  logic [RW-1:0] den_p;
  logic          vp;
  vtp_pkg::meta_t meta_s [QW];
  logic [QW-1:0] vs;
  logic [QW-1:0] quo [3];
  logic [CW-1:0] res [3];
  logic          sat_c;

  assign back_en = !out_valid || !out_stall;
  assign pop     = back_en && fifo_valid;

  // pre stage: signs, magnitudes, overflow check, affine clamp
  always_comb begin
    for (int i = 0; i < 4; i++) r[i] = signed'(fifo_data[i*RW +: RW]);
    wneg          = r[3][RW-1];
    wm            = wneg ? RW'(-r[3]) : RW'(r[3]);
    meta_c.action = fifo_data[4*RW];
    meta_c.dz     = (r[3] == '0);
    for (int i = 0; i < 3; i++) begin
      rm[i]                  = r[i][RW-1] ? RW'(-r[i]) : RW'(r[i]);
      num_c[i]               = {rm[i], {FRAC_BITS{1'b0}}};
      meta_c.lane[i].rneg    = r[i][RW-1];
      meta_c.lane[i].neg     = r[i][RW-1] ^ wneg;
      meta_c.lane[i].ovf     = (num_c[i] >> QW) >= NW'(wm);
      meta_c.lane[i].aff_sat = !((&r[i][RW-1:CW-1]) || !(|r[i][RW-1:CW-1]));
      meta_c.lane[i].aff_val = meta_c.lane[i].aff_sat
                             ? (r[i][RW-1] ? vtp_pkg::NEG_MIN : vtp_pkg::POS_MAX)
                             : r[i][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vp <= 1'b0;
    else if (back_en) vp <= pop;
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      meta_p <= meta_c;
      den_p  <= wm;
      for (int i = 0; i < 3; i++) num_p[i] <= num_c[i];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vtp_div #(.DW(RW)) u_div (
      .clk (clk),
      .en  (back_en),
      .num (num_p[i]),
      .den (den_p),
      .quo (quo[i])
    );
  end

  // metadata rides alongside the divider stages
  always_ff @(posedge clk) begin
    if (rst) vs <= '0;
    else if (back_en) vs <= {vs[QW-2:0], vp};
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      meta_s[0] <= meta_p;
      for (int j = 1; j < QW; j++) meta_s[j] <= meta_s[j-1];
    end
  end

  always_comb begin
    sat_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!meta_s[QW-1].action) begin
        res[i] = meta_s[QW-1].lane[i].aff_val;
        sat_c  = sat_c | meta_s[QW-1].lane[i].aff_sat;
      end else if (meta_s[QW-1].dz) begin
        res[i] = meta_s[QW-1].lane[i].rneg ? vtp_pkg::NEG_MIN : vtp_pkg::POS_MAX;
        sat_c  = 1'b1;
      end else if (meta_s[QW-1].lane[i].neg) begin
        if (meta_s[QW-1].lane[i].ovf || (quo[i] > vtp_pkg::NEG_MIN)) begin
          res[i] = vtp_pkg::NEG_MIN;
          sat_c  = 1'b1;
        end else begin
          res[i] = CW'(0) - quo[i];
        end
      end else begin
        if (meta_s[QW-1].lane[i].ovf || quo[i][QW-1]) begin
          res[i] = vtp_pkg::POS_MAX;
          sat_c  = 1'b1;
        end else begin
          res[i] = quo[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (back_en) out_valid <= vs[QW-1];
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      x_out          <= signed'(res[0]);
      y_out          <= signed'(res[1]);
      z_out          <= signed'(res[2]);
      saturated      <= sat_c;
      divide_by_zero <= meta_s[QW-1].action && meta_s[QW-1].dz;
    end
  end

  `VTP_ASSERT_IMP(a_dz_sets_sat, clk, rst, out_valid && divide_by_zero, saturated)
  `VTP_ASSERT_NXT(a_stall_freezes, clk, rst, out_valid && out_stall, $stable(vs) && out_valid)
  `VTP_ASSERT_NXT(a_last_to_out, clk, rst, vs[QW-1] && back_en, out_valid)

endmodule

[tb/tb_vertex_transform_project_core.sv]
module tb_vertex_transform_project_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC       = vtp_pkg::FRAC_BITS_DEF;
  localparam int DRAIN_WAIT = 48;        // extra wait after the last expected word
  localparam int CYCLE_CAP  = 600000;
  localparam int HOLD_AT    = 400;       // words sent before the long hold-off
  localparam int HOLD_LEN   = 300;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] PMAX = vtp_pkg::POS_MAX;
  localparam logic signed [31:0] NMIN = vtp_pkg::NEG_MIN;

  typedef enum int {MAT_IDENTITY, MAT_ZERO_W, MAT_ALL_MAX, MAT_ALL_MIN, MAT_RANDOM} mat_kind_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               sat, dz;
  } vertex_res_t;

  // directed row: expected value typed in when "typed" is set, else predicted
  typedef struct {
    mat_kind_t          kind;
    logic               act;
    logic signed [31:0] x, y, z;
    bit                 typed;
    vertex_res_t        res;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [vtp_pkg::CFG_IDX_W-1:0] wr_index = '0;
  logic [vtp_pkg::CFG_W-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic signed [vtp_pkg::COORD_W-1:0] x_in = '0, y_in = '0, z_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [vtp_pkg::COORD_W-1:0] x_out, y_out, z_out;
  logic saturated, divide_by_zero;

  vertex_transform_project_core dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .x_in(x_in), .y_in(y_in), .z_in(z_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .x_out(x_out), .y_out(y_out), .z_out(z_out),
    .saturated(saturated), .divide_by_zero(divide_by_zero)
  );

  always #10 clk = ~clk;

  // matrix mirror, kept in step with every write
  logic signed [31:0] mat [4][4];
  vertex_res_t expected_words [$];
  int errors = 0;
  int words_sent = 0;
  int cycles = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("vertex_transform_project_core: mismatch");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic logic signed [31:0] clip32(longint v, inout logic sat);
    if (v > longint'(PMAX)) begin
      sat = 1'b1;
      return PMAX;
    end
    if (v < longint'(NMIN)) begin
      sat = 1'b1;
      return NMIN;
    end
    return v[31:0];
  endfunction

  // r << FRAC / w, truncated toward zero, clipped to 32 bits
  function automatic logic signed [31:0] div_by_w(longint r, longint w, inout logic sat);
    logic [127:0] rm, wm, q;
    logic neg;
    rm  = (r < 0) ? 128'(-r) : 128'(r);
    wm  = (w < 0) ? 128'(-w) : 128'(w);
    neg = (r < 0) != (w < 0);
    q   = (rm << FRAC) / wm;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        return PMAX;
      end
      return q[31:0];
    end
    if (q > 128'h8000_0000) begin
      sat = 1'b1;
      return NMIN;
    end
    return -q[31:0];
  endfunction

  function automatic vertex_res_t project_point(logic act, logic signed [31:0] x,
                                                logic signed [31:0] y, logic signed [31:0] z);
    longint r [4];
    logic signed [31:0] o [3];
    vertex_res_t res;
    logic sat;
    sat = 1'b0;
    // each product floored by an arithmetic shift, then summed exactly
    for (int i = 0; i < 4; i++)
      r[i] = ((longint'(mat[i][0]) * longint'(x)) >>> FRAC) +
             ((longint'(mat[i][1]) * longint'(y)) >>> FRAC) +
             ((longint'(mat[i][2]) * longint'(z)) >>> FRAC) + longint'(mat[i][3]);
    res.dz = 1'b0;
    if (!act) begin
      for (int i = 0; i < 3; i++) o[i] = clip32(r[i], sat);
    end else if (r[3] == 0) begin
      // zero divisor: full scale by sign of the row sum
      res.dz = 1'b1;
      sat = 1'b1;
      for (int i = 0; i < 3; i++) o[i] = (r[i] < 0) ? NMIN : PMAX;
    end else begin
      for (int i = 0; i < 3; i++) o[i] = div_by_w(r[i], r[3], sat);
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    res.sat = sat;
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------
  // writes all eight registers plus one ignored index past the end
  task automatic load_matrix(input logic signed [31:0] m [4][4]);
    for (int k = 0; k < vtp_pkg::NUM_REGS; k++) begin
      wr_en    <= 1'b1;
      wr_index <= vtp_pkg::CFG_IDX_W'(k);
      wr_data  <= {m[k/2][2*(k%2)+1], m[k/2][2*(k%2)]};
      @(posedge clk);
      mat[k/2][2*(k%2)]   = m[k/2][2*(k%2)];
      mat[k/2][2*(k%2)+1] = m[k/2][2*(k%2)+1];
    end
    wr_en    <= 1'b1;
    wr_index <= vtp_pkg::CFG_IDX_W'($urandom_range(vtp_pkg::NUM_REGS,
                                                   2**vtp_pkg::CFG_IDX_W - 1));
    wr_data  <= {$urandom, $urandom};
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic send_point(logic act, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, bit typed, vertex_res_t res);
    in_valid <= 1'b1;
    action   <= act;
    x_in     <= x;
    y_in     <= y;
    z_in     <= z;
    do @(posedge clk); while (in_stall);
    expected_words.insert(expected_words.size(),
                          typed ? res : project_point(act, x, y, z));
    words_sent++;
    // bursts of random length, most followed by a random gap
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 30);
      if ($urandom_range(0, 4) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [31:0] rand_elem(int style);
    case (style)
      0: return $signed(32'($urandom_range(0, 32'h8_0000))) - 32'sh4_0000;
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 5))
          0: return 0;
          1: return PMAX;
          2: return NMIN;
          3: return ONE;
          4: return -ONE;
          default: return $urandom;
        endcase
      end
      default: return $signed(32'($urandom_range(0, 32'h2_0000))) - 32'sh1_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
    if (pick < 9) return $urandom;
    return pick[0] ? PMAX : NMIN;
  endfunction

  task automatic preset_matrix(mat_kind_t kind, int style);
    logic signed [31:0] m [4][4];
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        case (kind)
          MAT_IDENTITY: m[i][j] = (i == j) ? ONE : 0;
          MAT_ZERO_W:   m[i][j] = (i == j && i < 3) ? ONE : 0;
          MAT_ALL_MAX:  m[i][j] = PMAX;
          MAT_ALL_MIN:  m[i][j] = NMIN;
          default:      m[i][j] = rand_elem(style);
        endcase
    // style 3: w comes from the offset alone, often zero
    if (kind == MAT_RANDOM && style == 3) begin
      m[3][0] = 0;
      m[3][1] = 0;
      m[3][2] = 0;
      m[3][3] = $urandom_range(0, 1) ? 0 : rand_elem(0);
    end
    load_matrix(m);
  endtask

  // ---------------- receiver: stall pattern and checking ----------------
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && words_sent >= HOLD_AT) begin
        // one long hold-off so the block fills and stalls its input
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left  <= $urandom_range(20, 150);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    vertex_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (x_out !== e.x) begin
          $error("x_out expected %h got %h", e.x, x_out);
          errors++;
        end
        if (y_out !== e.y) begin
          $error("y_out expected %h got %h", e.y, y_out);
          errors++;
        end
        if (z_out !== e.z) begin
          $error("z_out expected %h got %h", e.z, z_out);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated expected %b got %b", e.sat, saturated);
          errors++;
        end
        if (divide_by_zero !== e.dz) begin
          $error("divide_by_zero expected %b got %b", e.dz, divide_by_zero);
          errors++;
        end
      end
    end
  end

  // ---------------- main sequence ----------------
  point_row_t directed [] = '{
    // identity after reset: points pass straight through, both actions
    '{MAT_IDENTITY, 1'b0, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 1'b1,
      '{32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 1'b0, 1'b0}},
    '{MAT_IDENTITY, 1'b1, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 1'b1,
      '{32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 1'b0, 1'b0}},
    '{MAT_IDENTITY, 1'b0, NMIN, PMAX, 0, 1'b1, '{NMIN, PMAX, 0, 1'b0, 1'b0}},
    '{MAT_IDENTITY, 1'b1, NMIN, PMAX, 0, 1'b1, '{NMIN, PMAX, 0, 1'b0, 1'b0}},
    '{MAT_IDENTITY, 1'b0, -1, 1, -1, 1'b1, '{-1, 1, -1, 1'b0, 1'b0}},
    '{MAT_IDENTITY, 1'b1, 32'sh5555_5555, -32'sh2AAA_AAAB, 32'sh7FFF_0000, 1'b0,
      '{0, 0, 0, 1'b0, 1'b0}},
    // w forced to zero: divide-by-zero fills by sign, affine unaffected
    '{MAT_ZERO_W, 1'b1, 5, -7, 0, 1'b1, '{PMAX, NMIN, PMAX, 1'b1, 1'b1}},
    '{MAT_ZERO_W, 1'b1, NMIN, PMAX, -1, 1'b1, '{NMIN, PMAX, NMIN, 1'b1, 1'b1}},
    '{MAT_ZERO_W, 1'b0, 5, -7, 0, 1'b1, '{5, -7, 0, 1'b0, 1'b0}},
    // full-scale matrices: clipping in both directions
    '{MAT_ALL_MAX, 1'b0, PMAX, PMAX, PMAX, 1'b0, '{0, 0, 0, 1'b0, 1'b0}},
    '{MAT_ALL_MAX, 1'b0, NMIN, NMIN, NMIN, 1'b0, '{0, 0, 0, 1'b0, 1'b0}},
    '{MAT_ALL_MAX, 1'b1, NMIN, PMAX, 1, 1'b0, '{0, 0, 0, 1'b0, 1'b0}},
    '{MAT_ALL_MAX, 1'b1, 32'sh0001_0000, 0, 0, 1'b0, '{0, 0, 0, 1'b0, 1'b0}},
    '{MAT_ALL_MIN, 1'b0, NMIN, NMIN, NMIN, 1'b0, '{0, 0, 0, 1'b0, 1'b0}},
    '{MAT_ALL_MIN, 1'b1, PMAX, -1, NMIN, 1'b0, '{0, 0, 0, 1'b0, 1'b0}},
    '{MAT_ALL_MIN, 1'b1, 0, 0, 0, 1'b0, '{0, 0, 0, 1'b0, 1'b0}}
  };

  initial begin
    mat_kind_t cur;
    vertex_res_t none;
    none = '{0, 0, 0, 1'b0, 1'b0};
    // mirror of the reset matrix
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) mat[i][j] = (i == j) ? ONE : 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur = MAT_IDENTITY;
    foreach (directed[n]) begin
      if (directed[n].kind != cur) begin
        drain_pipe();
        cur = directed[n].kind;
        preset_matrix(cur, 0);
      end
      send_point(directed[n].act, directed[n].x, directed[n].y, directed[n].z,
                 directed[n].typed, directed[n].res);
    end

    // random phases, each with a fresh matrix of its own flavor
    for (int p = 0; p < 6; p++) begin
      drain_pipe();
      preset_matrix(MAT_RANDOM, p % 4);
      repeat (250)
        send_point($urandom_range(0, 1), rand_coord(), rand_coord(), rand_coord(), 1'b0, none);
    end

    drain_pipe();
    if (errors == 0)
      $display("vertex_transform_project_core: match");
    else
      $display("vertex_transform_project_core: mismatch");
    $finish;
  end

endmodule

[vertex_transform_project_core.f]
+incdir+hdl
hdl/vtp_pkg.sv
hdl/vtp_front.sv
hdl/vtp_fifo.sv
hdl/vtp_div.sv
hdl/vtp_back.sv
hdl/vertex_transform_project_core.sv
tb/tb_vertex_transform_project_core.sv
